// ===== hw/rtl/hvo_pkg.sv =====
// Shared types, constants and helper functions for the haversine odometer.
// No dependencies; used by hvo_mul, hvo_cordic and the top level.
`timescale 1ns / 1ps

package hvo_pkg;

  // Default values for top-level parameters
  localparam int CORDIC_STEPS_DEF = 28;
  localparam int DIST_WIDTH_DEF   = 32;

  // Datapath widths
  localparam int CORD_W = 36;  // signed Q30 angle / vector width
  localparam int MUL_W  = 34;  // multiplier operand magnitude width

  // Q30 constants
  localparam logic signed [CORD_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CORD_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [CORD_W-1:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [CORD_W-1:0] GAIN_Q30    = 36'sh026DD3B6A;

  // Radians per 1e-7 degree, Q60
  localparam logic [63:0] RAD_PER_E7_Q60 = 64'h3243F6A8885A308D / 64'd1800000000;

  // Register indexes (address bit 2)
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_RADIUS    = 1'b1;

  // CORDIC command
  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_cmd_t;

  // Truncated Q30 arctangent table, zero past the end
  function automatic logic signed [CORD_W-1:0] atan_q30(input logic [5:0] idx);
    logic signed [CORD_W-1:0] v;
    case (idx)
      6'd0:  v = 36'sh03243F6A8;
      6'd1:  v = 36'sh01DAC6705;
      6'd2:  v = 36'sh00FADBAFC;
      6'd3:  v = 36'sh007F56EA6;
      6'd4:  v = 36'sh003FEAB76;
      6'd5:  v = 36'sh001FFD55B;
      6'd6:  v = 36'sh000FFFAAA;
      6'd7:  v = 36'sh0007FFF55;
      6'd8:  v = 36'sh0003FFFEA;
      6'd9:  v = 36'sh0001FFFFD;
      6'd10: v = 36'sh0000FFFFF;
      6'd11: v = 36'sh00007FFFF;
      6'd12: v = 36'sh00003FFFF;
      6'd13: v = 36'sh00001FFFF;
      6'd14: v = 36'sh00000FFFF;
      6'd15: v = 36'sh000007FFF;
      6'd16: v = 36'sh000003FFF;
      6'd17: v = 36'sh000001FFF;
      6'd18: v = 36'sh000000FFF;
      6'd19: v = 36'sh0000007FF;
      6'd20: v = 36'sh0000003FF;
      6'd21: v = 36'sh0000001FF;
      6'd22: v = 36'sh0000000FF;
      6'd23: v = 36'sh00000007F;
      6'd24: v = 36'sh00000003F;
      6'd25: v = 36'sh00000001F;
      6'd26: v = 36'sh00000000F;
      6'd27: v = 36'sh000000008;
      6'd28: v = 36'sh000000004;
      6'd29: v = 36'sh000000002;
      6'd30: v = 36'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Magnitude of a signed value, narrowed to the multiplier operand width
  function automatic logic [MUL_W-1:0] mag34(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W-1:0] n;
    n = v[CORD_W-1] ? -v : v;
    return n[MUL_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/hvo_mul.sv =====
// Iterative shift-add unsigned multiplier, one operand bit per cycle.
// Depends on hvo_pkg (MUL_W).
`timescale 1ns / 1ps

module hvo_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hvo_pkg::MUL_W-1:0]    a_i,
  input  logic [hvo_pkg::MUL_W-1:0]    b_i,
  output logic                         done_o,
  output logic [2*hvo_pkg::MUL_W-1:0]  p_o
);
  import hvo_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic [2*MUL_W-1:0] acc_q;
  logic [MUL_W-1:0]   mcand_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [MUL_W:0]     sum;

  // Add the multiplicand into the upper half when the current bit is set
  always_comb begin
    if (acc_q[0]) begin
      sum = {1'b0, acc_q[2*MUL_W-1:MUL_W]} + {1'b0, mcand_q};
    end else begin
      sum = {1'b0, acc_q[2*MUL_W-1:MUL_W]};
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= {{MUL_W{1'b0}}, b_i};
      mcand_q <= a_i;
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[MUL_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== hw/rtl/hvo_cordic.sv =====
// Shared CORDIC engine, rotation (sin/cos) or vectoring (atan) mode,
// one micro-rotation per cycle. Depends on hvo_pkg.
`timescale 1ns / 1ps

module hvo_cordic #(
  parameter int CORDIC_STEPS = hvo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hvo_pkg::cordic_cmd_t               cmd_i,
  input  logic signed [hvo_pkg::CORD_W-1:0]  x_i,
  input  logic signed [hvo_pkg::CORD_W-1:0]  y_i,
  input  logic signed [hvo_pkg::CORD_W-1:0]  z_i,
  output logic                               done_o,
  output logic signed [hvo_pkg::CORD_W-1:0]  x_o,
  output logic signed [hvo_pkg::CORD_W-1:0]  y_o,
  output logic signed [hvo_pkg::CORD_W-1:0]  z_o
);
  import hvo_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  logic signed [CORD_W-1:0] x_q, y_q, z_q;
  logic signed [CORD_W-1:0] dx, dy, at;
  logic [CNT_W-1:0]         cnt_q;
  logic                     vec_q;
  logic                     busy_q;
  logic                     done_q;
  logic                     up;

  // Shifted terms and rotation direction
  always_comb begin
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    at = atan_q30(6'(cnt_q));
    if (vec_q) begin
      up = y_q[CORD_W-1] || (y_q == '0);
    end else begin
      up = !z_q[CORD_W-1];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      vec_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        vec_q  <= cmd_i.vectoring;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Micro-rotation
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end else if (busy_q) begin
      if (up) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ===== hw/rtl/gps_haversine_odometer_unit.sv =====
// Haversine GPS odometer: top level with sequencer, square root and BCD.
// Depends on hvo_pkg, hvo_mul and hvo_cordic.
//
//  channel   | dir | handshake            | content
//  ----------+-----+----------------------+-------------------------------------
//  s_axis    | in  | tvalid/tready        | tdata: lat_e7, lon_e7; tuser: start
//  m_axis    | out | tvalid/tready        | tdata: step, total, reached, digits
//  apb       | in  | psel/penable, pready | threshold_dm @0x0, earth_radius_m @0x4
//
// A starting fix skips the distance computation and goes straight to BCD
// conversion. Any other fix is paced by the serial multiplier and the CORDIC
// engine, each used in turn. The input is ready only when the sequencer is
// idle; the result register lets a new fix start while the last result waits.
// Reset is asynchronous, active low.
`timescale 1ns / 1ps

module gps_haversine_odometer_unit #(
  parameter int CORDIC_STEPS = hvo_pkg::CORDIC_STEPS_DEF,
  parameter int DIST_WIDTH   = hvo_pkg::DIST_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [30:0] lat_e7, [62:31] lon_e7, [63] zero
  input  logic [63:0] s_axis_tdata_i,
  // tuser: [0] start_fix
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [31:0] step_dm, [63:32] total_dm, [64] reached, [68:65] hundreds,
  //        [72:69] tens, [76:73] ones, [80:77] tenths, [87:81] zero
  output logic [87:0] m_axis_tdata_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hvo_pkg::*;

  localparam int CMP_W  = (DIST_WIDTH > 32) ? DIST_WIDTH : 32;
  localparam int STP_W  = (DIST_WIDTH > 38) ? DIST_WIDTH : 38;
  localparam int BCNT_W = $clog2(DIST_WIDTH);
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};
  localparam logic [30:0] ONE_A = 31'h4000_0000;

  // Sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CONV   = 5'd1;
  localparam logic [4:0] S_CONV_W = 5'd2;
  localparam logic [4:0] S_WRAP   = 5'd3;
  localparam logic [4:0] S_FOLD   = 5'd4;
  localparam logic [4:0] S_ROT_W  = 5'd5;
  localparam logic [4:0] S_PROD   = 5'd6;
  localparam logic [4:0] S_PROD_W = 5'd7;
  localparam logic [4:0] S_SQI    = 5'd8;
  localparam logic [4:0] S_SQ     = 5'd9;
  localparam logic [4:0] S_VEC    = 5'd10;
  localparam logic [4:0] S_VEC_W  = 5'd11;
  localparam logic [4:0] S_DIST   = 5'd12;
  localparam logic [4:0] S_DIST_W = 5'd13;
  localparam logic [4:0] S_ACC    = 5'd14;
  localparam logic [4:0] S_BCDI   = 5'd15;
  localparam logic [4:0] S_BCD    = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  logic [4:0] state_q, state_d;
  logic [1:0] k_q;
  logic       sq_sel_q;

  // Configuration
  logic [31:0] thr_q;
  logic [23:0] rad_q;

  // Fix and state
  logic signed [30:0]       lat_q, prev_lat_q;
  logic signed [31:0]       lon_q, prev_lon_q;
  logic [DIST_WIDTH-1:0]    total_q, step_q;

  // Intermediate values
  logic signed [CORD_W-1:0] th_q, s1_q, s2_q, cp_q, cn_q, t1_q, t2_q, cc_q;
  logic                     flip_q, neg_q;
  logic [30:0]              a_q, ang_q;
  logic [31:0]              sy_q, sx_q;

  // Square root
  logic [63:0] sq_v_q, sq_r_q, sq_b_q, sq_rb, sq_r_nx;
  logic [4:0]  sq_cnt_q;

  // Binary to BCD
  logic [DIST_WIDTH-1:0] bcd_sh_q;
  logic [15:0]           bcd_q, bcd_adj;
  logic [BCNT_W-1:0]     bcd_cnt_q;

  // Output register
  logic        m_valid_q;
  logic [87:0] m_data_q;

  // Shared units
  logic                     mul_start, mul_done;
  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [2*MUL_W-1:0]       mul_p;
  cordic_cmd_t              cor_cmd;
  logic signed [CORD_W-1:0] cor_x_in, cor_y_in, cor_z_in, cor_x, cor_y, cor_z;
  logic                     cor_done;

  // Misc combinational
  logic signed [33:0]       ang_in;
  logic signed [CORD_W-1:0] ang_in_w, fold_th, prod_a, prod_b, t_new;
  logic                     fold_flip, mul_neg;
  logic [34:0]              thm;
  logic signed [2*MUL_W:0]  sp;
  logic signed [CORD_W:0]   a_sum;
  logic [37:0]              step_full;
  logic [STP_W-1:0]         step_ext;
  logic [DIST_WIDTH:0]      tot_sum;
  logic [CMP_W-1:0]         tot_cmp, step_cmp;
  logic                     in_acc;

  hvo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  hvo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cor_cmd),
    .x_i    (cor_x_in),
    .y_i    (cor_y_in),
    .z_i    (cor_z_in),
    .done_o (cor_done),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z)
  );

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // APB register file
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == REG_RADIUS) begin
      prdata = {8'd0, rad_q};
    end else begin
      prdata = thr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 32'd1000;
      rad_q <= 24'd6371000;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_THRESHOLD) begin
        thr_q <= pwdata;
      end else begin
        rad_q <= pwdata[23:0];
      end
    end
  end

  // Angle source for the degree-to-radian conversion
  always_comb begin
    case (k_q)
      2'd0:    ang_in = 34'(lat_q) - 34'(prev_lat_q);
      2'd1:    ang_in = 34'(lon_q) - 34'(prev_lon_q);
      2'd2:    ang_in = 34'(prev_lat_q);
      default: ang_in = 34'(lat_q);
    endcase
    ang_in_w = CORD_W'(ang_in);
  end

  // Product operand select
  always_comb begin
    case (k_q)
      2'd0:    begin prod_a = s1_q; prod_b = s1_q; end
      2'd1:    begin prod_a = s2_q; prod_b = s2_q; end
      2'd2:    begin prod_a = cp_q; prod_b = cn_q; end
      default: begin prod_a = cc_q; prod_b = t2_q; end
    endcase
  end

  // Multiplier command
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_neg   = 1'b0;
    case (state_q)
      S_CONV: begin
        mul_start = 1'b1;
        mul_a     = mag34(ang_in_w);
        mul_b     = MUL_W'(RAD_PER_E7_Q60);
        mul_neg   = ang_in[33];
      end
      S_PROD: begin
        mul_start = 1'b1;
        mul_a     = mag34(prod_a);
        mul_b     = mag34(prod_b);
        mul_neg   = prod_a[CORD_W-1] ^ prod_b[CORD_W-1];
      end
      S_DIST: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'({rad_q, 3'b000}) + MUL_W'({rad_q, 1'b0});
        mul_b     = MUL_W'({ang_q, 1'b0});
      end
      default: ;
    endcase
  end

  // Fold into [-pi/2, pi/2]
  always_comb begin
    fold_th   = th_q;
    fold_flip = 1'b0;
    if (th_q > HALF_PI_Q30) begin
      fold_th   = PI_Q30 - th_q;
      fold_flip = 1'b1;
    end else if (th_q < -HALF_PI_Q30) begin
      fold_th   = -PI_Q30 - th_q;
      fold_flip = 1'b1;
    end
  end

  // CORDIC command
  always_comb begin
    cor_cmd  = '0;
    cor_x_in = GAIN_Q30;
    cor_y_in = '0;
    cor_z_in = fold_th;
    if (state_q == S_FOLD) begin
      cor_cmd.start = 1'b1;
    end else if (state_q == S_VEC) begin
      cor_cmd.start     = 1'b1;
      cor_cmd.vectoring = 1'b1;
      cor_x_in          = CORD_W'(sx_q);
      cor_y_in          = CORD_W'(sy_q);
      cor_z_in          = '0;
    end
  end

  // Result shaping
  always_comb begin
    if (k_q[1]) begin
      thm = 35'(mul_p >> 30);
    end else begin
      thm = 35'(mul_p >> 31);
    end
    sp        = neg_q ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
    t_new     = CORD_W'(sp >>> 30);
    a_sum     = (CORD_W+1)'(t1_q) + (CORD_W+1)'(t_new);
    step_full = 38'((mul_p + (2*MUL_W)'(1 << 29)) >> 30);
    step_ext  = STP_W'(step_full);
    tot_sum   = {1'b0, total_q} + {1'b0, step_q};
    tot_cmp   = CMP_W'(total_q);
    step_cmp  = CMP_W'(step_q);
  end

  // Square root step
  always_comb begin
    sq_rb = sq_r_q + sq_b_q;
    if (sq_v_q >= sq_rb) begin
      sq_r_nx = (sq_r_q >> 1) + sq_b_q;
    end else begin
      sq_r_nx = sq_r_q >> 1;
    end
  end

  // Add-3 adjust of four BCD digits
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = s_axis_tuser_i[0] ? S_BCDI : S_CONV;
      S_CONV:   state_d = S_CONV_W;
      S_CONV_W: if (mul_done) state_d = S_WRAP;
      S_WRAP:   state_d = S_FOLD;
      S_FOLD:   state_d = S_ROT_W;
      S_ROT_W:  if (cor_done) state_d = (k_q == 2'd3) ? S_PROD : S_CONV;
      S_PROD:   state_d = S_PROD_W;
      S_PROD_W: if (mul_done) state_d = (k_q == 2'd3) ? S_SQI : S_PROD;
      S_SQI:    state_d = S_SQ;
      S_SQ:     if (sq_cnt_q == 5'd31) state_d = sq_sel_q ? S_VEC : S_SQI;
      S_VEC:    state_d = S_VEC_W;
      S_VEC_W:  if (cor_done) state_d = S_DIST;
      S_DIST:   state_d = S_DIST_W;
      S_DIST_W: if (mul_done) state_d = S_ACC;
      S_ACC:    state_d = S_BCDI;
      S_BCDI:   state_d = S_BCD;
      S_BCD:    if (bcd_cnt_q == BCNT_W'(DIST_WIDTH - 1)) state_d = S_OUT;
      S_OUT:    if (!m_valid_q || m_axis_tready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      k_q        <= '0;
      sq_sel_q   <= 1'b0;
      prev_lat_q <= '0;
      prev_lon_q <= '0;
      total_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        k_q      <= '0;
        sq_sel_q <= 1'b0;
      end
      if (state_q == S_ROT_W && cor_done) k_q <= k_q + 1'b1;
      if (state_q == S_PROD_W && mul_done) k_q <= k_q + 1'b1;
      if (state_q == S_SQ && sq_cnt_q == 5'd31) sq_sel_q <= 1'b1;
      // Saturating accumulate
      if (state_q == S_ACC) begin
        total_q <= tot_sum[DIST_WIDTH] ? DIST_MAX : tot_sum[DIST_WIDTH-1:0];
      end
      // Result handoff
      if (state_q == S_OUT && (!m_valid_q || m_axis_tready_i)) begin
        m_valid_q  <= 1'b1;
        prev_lat_q <= lat_q;
        prev_lon_q <= lon_q;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          lat_q  <= $signed(s_axis_tdata_i[30:0]);
          lon_q  <= $signed(s_axis_tdata_i[62:31]);
          step_q <= '0;
        end
      end
      S_CONV: neg_q <= mul_neg;
      S_CONV_W: begin
        if (mul_done) begin
          th_q <= neg_q ? -$signed({1'b0, thm}) : $signed({1'b0, thm});
        end
      end
      // Bring the angle into [-pi, pi]
      S_WRAP: begin
        if (th_q > PI_Q30) begin
          th_q <= th_q - TWO_PI_Q30;
        end else if (th_q < -PI_Q30) begin
          th_q <= th_q + TWO_PI_Q30;
        end
      end
      S_FOLD: flip_q <= fold_flip;
      S_ROT_W: begin
        if (cor_done) begin
          case (k_q)
            2'd0:    s1_q <= cor_y;
            2'd1:    s2_q <= cor_y;
            2'd2:    cp_q <= flip_q ? -cor_x : cor_x;
            default: cn_q <= flip_q ? -cor_x : cor_x;
          endcase
        end
      end
      S_PROD: neg_q <= mul_neg;
      S_PROD_W: begin
        if (mul_done) begin
          case (k_q)
            2'd0: t1_q <= t_new;
            2'd1: t2_q <= t_new;
            2'd2: cc_q <= t_new;
            default: begin
              // Clamp the haversine term to [0, 1]
              if (a_sum[CORD_W]) begin
                a_q <= '0;
              end else if (a_sum > (CORD_W+1)'(ONE_Q30)) begin
                a_q <= ONE_A;
              end else begin
                a_q <= a_sum[30:0];
              end
            end
          endcase
        end
      end
      S_SQI: begin
        sq_v_q   <= sq_sel_q ? {3'd0, ONE_A - a_q, 30'd0} : {3'd0, a_q, 30'd0};
        sq_r_q   <= '0;
        sq_b_q   <= 64'h4000_0000_0000_0000;
        sq_cnt_q <= '0;
      end
      S_SQ: begin
        if (sq_v_q >= sq_rb) sq_v_q <= sq_v_q - sq_rb;
        sq_r_q   <= sq_r_nx;
        sq_b_q   <= sq_b_q >> 2;
        sq_cnt_q <= sq_cnt_q + 1'b1;
        if (sq_cnt_q == 5'd31) begin
          if (sq_sel_q) begin
            sx_q <= sq_r_nx[31:0];
          end else begin
            sy_q <= sq_r_nx[31:0];
          end
        end
      end
      // Clamp the central half-angle to [0, pi/2]
      S_VEC_W: begin
        if (cor_done) begin
          if (cor_z[CORD_W-1]) begin
            ang_q <= '0;
          end else if (cor_z > HALF_PI_Q30) begin
            ang_q <= HALF_PI_Q30[30:0];
          end else begin
            ang_q <= cor_z[30:0];
          end
        end
      end
      S_DIST_W: begin
        if (mul_done) begin
          step_q <= (step_ext > STP_W'(DIST_MAX)) ? DIST_MAX : step_ext[DIST_WIDTH-1:0];
        end
      end
      S_BCDI: begin
        bcd_sh_q  <= total_q;
        bcd_q     <= '0;
        bcd_cnt_q <= '0;
      end
      S_BCD: begin
        bcd_q     <= {bcd_adj[14:0], bcd_sh_q[DIST_WIDTH-1]};
        bcd_sh_q  <= bcd_sh_q << 1;
        bcd_cnt_q <= bcd_cnt_q + 1'b1;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_data_q <= {7'd0, bcd_q[3:0], bcd_q[7:4], bcd_q[11:8], bcd_q[15:12],
                       (tot_cmp >= CMP_W'(thr_q)), tot_cmp[31:0], step_cmp[31:0]};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTH
  // A starting fix goes straight to digit conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser_i[0] |=> state_q == S_BCDI)
    else $error("start fix did not skip distance computation");

  // The running total never decreases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> total_q >= $past(total_q))
    else $error("total distance decreased");

  // Haversine term is clamped before the square roots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQI |-> a_q <= ONE_A)
    else $error("haversine term above one");

  // Multiplier results arrive only in a waiting state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_CONV_W || state_q == S_PROD_W || state_q == S_DIST_W))
    else $error("unexpected multiplier completion");
`endif

endmodule
